### sv/numeric_field_classifier_macros.svh
// Assertion macros for the numeric field classifier.
`ifndef NUMERIC_FIELD_CLASSIFIER_MACROS_SVH
`define NUMERIC_FIELD_CLASSIFIER_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define NFC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define NFC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/nfc_pkg.sv
// Package for the numeric field classifier: parse phases and byte constants.
`default_nettype none

package nfc_pkg;

  // Longest field accepted, in bytes
  localparam logic [15:0] MAX_FIELD_BYTES = 16'd65535;

  // Configuration registers
  localparam logic [3:0] AFFIX_LIMIT_RESET = 4'd4;
  localparam logic       REG_AFFIX_LIMIT   = 1'b0;

  // Byte codes
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;

  // Parse phase of the field scanner
  typedef enum logic [3:0] {
    PH_START   = 4'd0,
    PH_AFFIX   = 4'd1,
    PH_GAP     = 4'd2,
    PH_SIGN    = 4'd3,
    PH_LEADSEP = 4'd4,
    PH_INT     = 4'd5,
    PH_FRAC    = 4'd6,
    PH_GAP2    = 4'd7,
    PH_SUFFIX  = 4'd8,
    PH_TRAIL   = 4'd9
  } phase_t;

endpackage

`default_nettype wire

### sv/numeric_field_classifier.sv
// Numeric field classifier: byte-serial scanner with a registered result.
//
// Usage:
//   Input channel (in_valid / in_stall / char_byte / last_byte) takes one byte
//   of a text field per transfer; last_byte marks the field's final byte.
//   Output channel (out_valid / out_stall / accepted / token_* / flags) gives
//   one result per field, for the transfer that carried last_byte.
//   Throughput is one byte per cycle: each byte updates the scan state in the
//   cycle it is taken, through a single level of decode and compare logic.
//   out_valid rises in the cycle after the final byte's transfer.
//   The result register is the only buffer: while it holds a result that the
//   receiver stalls, in_stall is high and every byte waits, whether or not
//   it ends a field; otherwise bytes keep flowing.
//   Reset (synchronous, rst high) empties the result register, returns the
//   scanner to the start of a field and sets the affix limit to 4.
//   The affix limit (register 0, byte address 0) must be written over the APB
//   port only between fields; the block does not enforce this. pready is always high.
//   When a field is rejected, every result field besides accepted is zero.
`default_nettype none

module numeric_field_classifier (
  input  wire logic        clk,
  input  wire logic        rst,
  // APB configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  // Input byte stream
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  char_byte,
  input  wire logic        last_byte,
  // Result stream
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             accepted,
  output logic      [15:0] token_start,
  output logic      [15:0] token_end,
  output logic      [15:0] integer_digits,
  output logic             sign_seen,
  output logic             decimal_seen
);

  // Configuration register
  logic [3:0] affix_length_limit;

  // Scan state
  nfc_pkg::phase_t phase, phase_next, phase_upd;
  logic [15:0] byte_position, byte_position_next, byte_position_upd;
  logic [15:0] start_offset, start_offset_next, start_offset_upd;
  logic [15:0] end_offset, end_offset_next, end_offset_upd;
  logic [15:0] digit_count, digit_count_next, digit_count_upd;
  logic [3:0]  affix_count, affix_count_next, affix_count_upd;
  logic        affix_has_letter, affix_has_letter_next, affix_has_letter_upd;
  logic        affix_has_symbol, affix_has_symbol_next, affix_has_symbol_upd;
  logic        sign_flag, sign_flag_next, sign_flag_upd;
  logic        decimal_flag, decimal_flag_next, decimal_flag_upd;
  logic        reject_flag, reject_flag_next, reject_flag_upd;

  // Byte classes
  logic is_dig, is_sgn, is_sep, is_blank, is_let;

  // Handshake and result
  logic        in_xfer, res_load, out_valid_next;
  logic        res_ok, res_open;
  logic [15:0] res_end;

  // Check terms
  logic        res_zero, scan_clear;

  // APB: always ready, one register at index 0
  assign pready = 1'b1;

  always_comb begin
    prdata = '0;
    if (paddr[2] == nfc_pkg::REG_AFFIX_LIMIT) begin
      prdata = {28'd0, affix_length_limit};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      affix_length_limit <= nfc_pkg::AFFIX_LIMIT_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == nfc_pkg::REG_AFFIX_LIMIT) begin
      affix_length_limit <= pwdata[3:0];
    end
  end

  // Classify the incoming byte
  always_comb begin
    is_dig   = (char_byte >= nfc_pkg::CH_ZERO) && (char_byte <= nfc_pkg::CH_NINE);
    is_sgn   = (char_byte == nfc_pkg::CH_PLUS) || (char_byte == nfc_pkg::CH_MINUS);
    is_sep   = (char_byte == nfc_pkg::CH_DOT) || (char_byte == nfc_pkg::CH_COMMA);
    is_blank = (char_byte == nfc_pkg::CH_SPACE) || (char_byte == nfc_pkg::CH_TAB);
    is_let   = ((char_byte >= nfc_pkg::CH_UPPER_A) && (char_byte <= nfc_pkg::CH_UPPER_Z)) ||
               ((char_byte >= nfc_pkg::CH_LOWER_A) && (char_byte <= nfc_pkg::CH_LOWER_Z));
  end

  // Handshake: hold off input only while a finished result is stalled
  assign in_stall = out_valid && out_stall;
  assign in_xfer  = in_valid && !in_stall;
  assign res_load = in_xfer && last_byte;

  // Scan step: state after this byte
  always_comb begin
    phase_upd            = phase;
    start_offset_upd     = start_offset;
    end_offset_upd       = end_offset;
    digit_count_upd      = digit_count;
    affix_count_upd      = affix_count;
    affix_has_letter_upd = affix_has_letter;
    affix_has_symbol_upd = affix_has_symbol;
    sign_flag_upd        = sign_flag;
    decimal_flag_upd     = decimal_flag;
    reject_flag_upd      = reject_flag || (byte_position >= nfc_pkg::MAX_FIELD_BYTES);

    unique case (phase)
      nfc_pkg::PH_START, nfc_pkg::PH_AFFIX, nfc_pkg::PH_GAP: begin
        if (is_dig) begin
          start_offset_upd = byte_position;
          digit_count_upd  = 16'd1;
          phase_upd        = nfc_pkg::PH_INT;
        end else if (is_sgn) begin
          start_offset_upd = byte_position;
          sign_flag_upd    = 1'b1;
          phase_upd        = nfc_pkg::PH_SIGN;
        end else if (is_sep) begin
          start_offset_upd = byte_position;
          decimal_flag_upd = 1'b1;
          phase_upd        = nfc_pkg::PH_LEADSEP;
        end else if (is_blank) begin
          if (phase == nfc_pkg::PH_START) begin
            reject_flag_upd = 1'b1;
          end
          phase_upd = nfc_pkg::PH_GAP;
        end else begin
          // Prefix byte: a second prefix run after a gap is not allowed
          if (phase == nfc_pkg::PH_GAP) begin
            reject_flag_upd = 1'b1;
          end
          if (affix_count >= affix_length_limit) begin
            reject_flag_upd = 1'b1;
          end else begin
            affix_count_upd = affix_count + 4'd1;
          end
          affix_has_letter_upd = affix_has_letter || is_let;
          affix_has_symbol_upd = affix_has_symbol || !is_let;
          if (affix_has_letter_upd && affix_has_symbol_upd) begin
            reject_flag_upd = 1'b1;
          end
          phase_upd = nfc_pkg::PH_AFFIX;
        end
      end
      nfc_pkg::PH_SIGN: begin
        if (is_dig) begin
          digit_count_upd = 16'd1;
          phase_upd       = nfc_pkg::PH_INT;
        end else if (is_sep) begin
          decimal_flag_upd = 1'b1;
          phase_upd        = nfc_pkg::PH_LEADSEP;
        end else begin
          reject_flag_upd = 1'b1;
        end
      end
      nfc_pkg::PH_LEADSEP: begin
        if (is_dig) begin
          phase_upd = nfc_pkg::PH_FRAC;
        end else begin
          reject_flag_upd = 1'b1;
        end
      end
      nfc_pkg::PH_INT, nfc_pkg::PH_FRAC: begin
        if (is_dig) begin
          if (phase == nfc_pkg::PH_INT && digit_count != 16'hFFFF) begin
            digit_count_upd = digit_count + 16'd1;
          end
        end else if (is_sep && phase == nfc_pkg::PH_INT) begin
          decimal_flag_upd = 1'b1;
          phase_upd        = nfc_pkg::PH_FRAC;
        end else if (is_sep || is_sgn) begin
          reject_flag_upd = 1'b1;
        end else if (is_blank) begin
          end_offset_upd = byte_position;
          phase_upd      = nfc_pkg::PH_GAP2;
        end else begin
          // Suffix starts right after the token
          end_offset_upd = byte_position;
          if (affix_length_limit == 4'd0) begin
            reject_flag_upd = 1'b1;
            affix_count_upd = 4'd0;
          end else begin
            affix_count_upd = 4'd1;
          end
          affix_has_letter_upd = is_let;
          affix_has_symbol_upd = !is_let;
          phase_upd            = nfc_pkg::PH_SUFFIX;
        end
      end
      nfc_pkg::PH_GAP2: begin
        if (is_dig || is_sgn || is_sep) begin
          reject_flag_upd = 1'b1;
        end else if (!is_blank) begin
          // Suffix after blanks; token end already recorded
          if (affix_length_limit == 4'd0) begin
            reject_flag_upd = 1'b1;
            affix_count_upd = 4'd0;
          end else begin
            affix_count_upd = 4'd1;
          end
          affix_has_letter_upd = is_let;
          affix_has_symbol_upd = !is_let;
          phase_upd            = nfc_pkg::PH_SUFFIX;
        end
      end
      nfc_pkg::PH_SUFFIX: begin
        if (is_dig || is_sgn || is_sep) begin
          reject_flag_upd = 1'b1;
        end else if (is_blank) begin
          phase_upd = nfc_pkg::PH_TRAIL;
        end else begin
          if (affix_count >= affix_length_limit) begin
            reject_flag_upd = 1'b1;
          end else begin
            affix_count_upd = affix_count + 4'd1;
          end
          affix_has_letter_upd = affix_has_letter || is_let;
          affix_has_symbol_upd = affix_has_symbol || !is_let;
          if (affix_has_letter_upd && affix_has_symbol_upd) begin
            reject_flag_upd = 1'b1;
          end
        end
      end
      default: begin
        // Trailing blanks only
        if (!is_blank) begin
          reject_flag_upd = 1'b1;
        end
      end
    endcase

    byte_position_upd = (byte_position != 16'hFFFF) ? byte_position + 16'd1 : byte_position;
  end

  // Verdict at the final byte
  always_comb begin
    res_open = (phase_upd == nfc_pkg::PH_INT) || (phase_upd == nfc_pkg::PH_FRAC);
    res_ok   = !reject_flag_upd && !is_blank &&
               (res_open || (phase_upd == nfc_pkg::PH_SUFFIX));
    res_end  = res_open ? byte_position + 16'd1 : end_offset_upd;
  end

  // Next state: clear after the final byte
  always_comb begin
    if (last_byte) begin
      phase_next            = nfc_pkg::PH_START;
      byte_position_next    = '0;
      start_offset_next     = '0;
      end_offset_next       = '0;
      digit_count_next      = '0;
      affix_count_next      = '0;
      affix_has_letter_next = 1'b0;
      affix_has_symbol_next = 1'b0;
      sign_flag_next        = 1'b0;
      decimal_flag_next     = 1'b0;
      reject_flag_next      = 1'b0;
    end else begin
      phase_next            = phase_upd;
      byte_position_next    = byte_position_upd;
      start_offset_next     = start_offset_upd;
      end_offset_next       = end_offset_upd;
      digit_count_next      = digit_count_upd;
      affix_count_next      = affix_count_upd;
      affix_has_letter_next = affix_has_letter_upd;
      affix_has_symbol_next = affix_has_symbol_upd;
      sign_flag_next        = sign_flag_upd;
      decimal_flag_next     = decimal_flag_upd;
      reject_flag_next      = reject_flag_upd;
    end
  end

  // Scan state register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= nfc_pkg::PH_START;
      byte_position    <= '0;
      start_offset     <= '0;
      end_offset       <= '0;
      digit_count      <= '0;
      affix_count      <= '0;
      affix_has_letter <= 1'b0;
      affix_has_symbol <= 1'b0;
      sign_flag        <= 1'b0;
      decimal_flag     <= 1'b0;
      reject_flag      <= 1'b0;
    end else if (in_xfer) begin
      phase            <= phase_next;
      byte_position    <= byte_position_next;
      start_offset     <= start_offset_next;
      end_offset       <= end_offset_next;
      digit_count      <= digit_count_next;
      affix_count      <= affix_count_next;
      affix_has_letter <= affix_has_letter_next;
      affix_has_symbol <= affix_has_symbol_next;
      sign_flag        <= sign_flag_next;
      decimal_flag     <= decimal_flag_next;
      reject_flag      <= reject_flag_next;
    end
  end

  // Result register
  always_comb begin
    if (res_load) begin
      out_valid_next = 1'b1;
    end else if (!out_stall) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      accepted       <= res_ok;
      token_start    <= res_ok ? start_offset_upd : 16'd0;
      token_end      <= res_ok ? res_end : 16'd0;
      integer_digits <= res_ok ? digit_count_upd : 16'd0;
      sign_seen      <= res_ok && sign_flag_upd;
      decimal_seen   <= res_ok && decimal_flag_upd;
    end
  end

  // Checks
  assign res_zero   = (token_start == 16'd0) && (token_end == 16'd0) &&
                      (integer_digits == 16'd0) && !sign_seen && !decimal_seen;
  assign scan_clear = (phase == nfc_pkg::PH_START) && (byte_position == 16'd0) &&
                      !reject_flag;

`include "numeric_field_classifier_macros.svh"

  `NFC_ASSERT_SAME(a_reject_fields_zero, out_valid && !accepted, res_zero, "reject not zeroed")
  `NFC_ASSERT_SAME(a_token_nonempty, out_valid && accepted, token_end > token_start, "empty token")
  `NFC_ASSERT_NEXT(a_final_byte_result, res_load, out_valid, "final byte gave no result")
  `NFC_ASSERT_NEXT(a_field_cleared, res_load, scan_clear, "scan state not cleared")

endmodule

`default_nettype wire
